// ===== hdl/spring_force_limited_macros.svh =====
// Assertion macros for the spring force block.
// Depends on signals clk and rst in the module that includes it.
`ifndef SPRING_FORCE_LIMITED_MACROS_SVH
`define SPRING_FORCE_LIMITED_MACROS_SVH

// same-cycle implication
`define SFL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication
`define SFL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

// ===== hdl/sfl_pkg.sv =====
// Shared widths, register layout, codes and pipeline types for the spring force block.
// No dependencies.
package sfl_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FORCE_FRAC_DEF  = 24;

  localparam int FIELD_W   = 32;
  localparam int PARAM_W   = 64;
  localparam int KIND_W    = 2;
  localparam int NUM_KINDS = 4;

  localparam int REST_LSB   = 0;
  localparam int REST_W     = 24;
  localparam int K_LSB      = 24;
  localparam int K_W        = 20;
  localparam int LIM_LSB    = 44;
  localparam int LIM_W      = 20;
  localparam int REST_SHIFT = 8;
  localparam int CAP_SHIFT  = 16;

  localparam int DIFF_W   = 33;
  localparam int ABS_W    = 32;
  localparam int SQ_W     = 64;
  localparam int SUM_W    = 65;
  localparam int DIST_W   = 33;
  localparam int STR_W    = 34;
  localparam int AS_W     = 33;
  localparam int MR_W     = 53;
  localparam int MAG_W    = 36;
  localparam int MAG_FRAC = 32;
  localparam int Q_W      = 31;
  localparam int Q_FRAC   = 30;
  localparam int PROD_W   = MAG_W + Q_W;

  localparam logic [FIELD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam int FRONT_STAGES = 4;
  localparam int SQRT_STAGES  = DIST_W;
  localparam int SCALE_STAGES = 4;
  localparam int DIV_STAGES   = Q_W;
  localparam int BACK_STAGES  = 2;
  localparam int LATENCY = FRONT_STAGES + SQRT_STAGES + SCALE_STAGES + DIV_STAGES
                           + BACK_STAGES;

  typedef enum logic [KIND_W-1:0] {
    IDX_DEFAULT,
    IDX_JOINT,
    IDX_MEMBRANE,
    IDX_STRUCTURE
  } cfg_idx_t;

  typedef struct packed {
    logic [REST_W-1:0] rest;
    logic [K_W-1:0]    kval;
    logic [LIM_W-1:0]  lim;
    logic [ABS_W-1:0]  ax;
    logic [ABS_W-1:0]  ay;
    logic              dx_neg;
    logic              dy_neg;
  } geom_t;

  typedef struct packed {
    logic [MAG_W-1:0]   mag;
    logic [FIELD_W-1:0] ext;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
  } div_tag_t;

endpackage

// ===== hdl/spring_force_limited.sv =====
// Top level of the clamped spring force block: parameter registers, pipeline, output stages.
// Depends on sfl_pkg, sfl_front, sfl_sqrt, sfl_scale, sfl_div and the assertion macros.
//
//  channel  | handshake              | beat contents
//  ---------+------------------------+---------------------------------------------
//  command  | start / busy           | spring_kind, a_x, a_y, b_x, b_y
//  result   | done (one-cycle strobe)| force_x, force_y, extension
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One command beat per cycle; busy stays low. Each result passes through the 33-stage
// square root and the 31-stage divider lanes.
// Synchronous reset clears the parameter registers and all stage valid bits.
// The result side takes every beat, so nothing in the pipeline ever stalls.
`include "spring_force_limited_macros.svh"

module spring_force_limited #(
  parameter int COORD_WIDTH     = sfl_pkg::COORD_WIDTH_DEF,
  parameter int FORCE_FRAC_BITS = sfl_pkg::FORCE_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sfl_pkg::KIND_W-1:0]   spring_kind,
  input  logic [sfl_pkg::FIELD_W-1:0]  a_x,
  input  logic [sfl_pkg::FIELD_W-1:0]  a_y,
  input  logic [sfl_pkg::FIELD_W-1:0]  b_x,
  input  logic [sfl_pkg::FIELD_W-1:0]  b_y,
  output logic                         done,
  output logic [sfl_pkg::FIELD_W-1:0]  force_x,
  output logic [sfl_pkg::FIELD_W-1:0]  force_y,
  output logic [sfl_pkg::FIELD_W-1:0]  extension,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfl_pkg::KIND_W-1:0]   cfg_index,
  input  logic [sfl_pkg::PARAM_W-1:0]  cfg_data
);
  import sfl_pkg::*;

  localparam int MAG_SHIFT = MAG_FRAC - FORCE_FRAC_BITS;
  localparam int SH_W      = PROD_W - Q_FRAC;

  logic [PARAM_W-1:0] kind_regs [NUM_KINDS];

  logic               fr_valid;
  logic [SUM_W-1:0]   fr_sum;
  geom_t              fr_geom;
  logic               sq_valid;
  logic [DIST_W-1:0]  sq_dist;
  geom_t              sq_geom;
  logic               sc_valid;
  logic [ABS_W-1:0]   sc_ax, sc_ay;
  logic [DIST_W-1:0]  sc_dist;
  div_tag_t           sc_tag;
  logic               dv_valid;
  logic [Q_W-1:0]     dv_qx, dv_qy;
  div_tag_t           dv_tag;

  logic               p1_valid, p1_negx, p1_negy, p1_zero;
  logic [PROD_W-1:0]  p1_px, p1_py;
  logic [FIELD_W-1:0] p1_ext;
  logic [MAG_W-1:0]   mag_s;
  logic [SH_W-1:0]    shx, shy;
  logic [FIELD_W-1:0] fx_next, fy_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KINDS; i++) begin
        kind_regs[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        IDX_DEFAULT:   kind_regs[IDX_DEFAULT]   <= cfg_data;
        IDX_JOINT:     kind_regs[IDX_JOINT]     <= cfg_data;
        IDX_MEMBRANE:  kind_regs[IDX_MEMBRANE]  <= cfg_data;
        IDX_STRUCTURE: kind_regs[IDX_STRUCTURE] <= cfg_data;
        default: ;
      endcase
    end
  end

  sfl_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .params   (kind_regs[spring_kind]),
    .a_x      (a_x),
    .a_y      (a_y),
    .b_x      (b_x),
    .b_y      (b_y),
    .out_valid(fr_valid),
    .out_sum  (fr_sum),
    .out_geom (fr_geom)
  );

  sfl_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .in_sum   (fr_sum),
    .in_geom  (fr_geom),
    .out_valid(sq_valid),
    .out_dist (sq_dist),
    .out_geom (sq_geom)
  );

  sfl_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_dist  (sq_dist),
    .in_geom  (sq_geom),
    .out_valid(sc_valid),
    .out_ax   (sc_ax),
    .out_ay   (sc_ay),
    .out_dist (sc_dist),
    .out_tag  (sc_tag)
  );

  sfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sc_valid),
    .in_ax    (sc_ax),
    .in_ay    (sc_ay),
    .in_dist  (sc_dist),
    .in_tag   (sc_tag),
    .out_valid(dv_valid),
    .out_qx   (dv_qx),
    .out_qy   (dv_qy),
    .out_tag  (dv_tag)
  );

  assign mag_s = dv_tag.mag >> MAG_SHIFT;
  assign shx   = p1_px[PROD_W-1:Q_FRAC];
  assign shy   = p1_py[PROD_W-1:Q_FRAC];

  always_comb begin
    if (p1_zero) begin
      fx_next = '0;
    end else if (p1_negx) begin
      fx_next = (shx[SH_W-1:FIELD_W-1] != '0) ? SAT_NEG : FIELD_W'(-shx);
    end else begin
      fx_next = (shx[SH_W-1:FIELD_W-1] != '0) ? SAT_POS : shx[FIELD_W-1:0];
    end
    if (p1_zero) begin
      fy_next = '0;
    end else if (p1_negy) begin
      fy_next = (shy[SH_W-1:FIELD_W-1] != '0) ? SAT_NEG : FIELD_W'(-shy);
    end else begin
      fy_next = (shy[SH_W-1:FIELD_W-1] != '0) ? SAT_POS : shy[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      p1_valid <= dv_valid;
      done     <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_px   <= PROD_W'(mag_s) * PROD_W'(dv_qx);
    p1_py   <= PROD_W'(mag_s) * PROD_W'(dv_qy);
    p1_negx <= dv_tag.neg_x;
    p1_negy <= dv_tag.neg_y;
    p1_zero <= dv_tag.zero;
    p1_ext  <= dv_tag.ext;

    force_x   <= fx_next;
    force_y   <= fy_next;
    extension <= p1_ext;
  end

  `SFL_ASSERT_IMP(a_latency, start && !busy, ##LATENCY done, "result strobe missing after command")
  `SFL_ASSERT_NXT(a_zero_force, p1_valid && p1_zero, force_x == '0 && force_y == '0, "force not zero for degenerate spring")
  `SFL_ASSERT_NXT(a_sign_x, p1_valid && !p1_negx, !force_x[FIELD_W-1], "x force negative on positive path")

endmodule

// ===== hdl/sfl_front.sv =====
// Front stages: parameter unpack, difference, absolute value, squares, sum.
// Depends on sfl_pkg.
module sfl_front #(
  parameter int COORD_WIDTH = sfl_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [sfl_pkg::PARAM_W-1:0]   params,
  input  logic [sfl_pkg::FIELD_W-1:0]   a_x,
  input  logic [sfl_pkg::FIELD_W-1:0]   a_y,
  input  logic [sfl_pkg::FIELD_W-1:0]   b_x,
  input  logic [sfl_pkg::FIELD_W-1:0]   b_y,
  output logic                          out_valid,
  output logic [sfl_pkg::SUM_W-1:0]     out_sum,
  output sfl_pkg::geom_t                out_geom
);
  import sfl_pkg::*;

  localparam int CW  = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int PAD = DIFF_W - CW;

  logic signed [DIFF_W-1:0] ax_e, ay_e, bx_e, by_e, dx, dy;
  logic signed [DIFF_W-1:0] dx1, dy1;
  logic                     v1, v2, v3;
  geom_t                    g1, g2, g3;
  logic [SQ_W-1:0]          sx3, sy3;

  assign ax_e = signed'({{PAD{a_x[CW-1]}}, a_x[CW-1:0]});
  assign ay_e = signed'({{PAD{a_y[CW-1]}}, a_y[CW-1:0]});
  assign bx_e = signed'({{PAD{b_x[CW-1]}}, b_x[CW-1:0]});
  assign by_e = signed'({{PAD{b_y[CW-1]}}, b_y[CW-1:0]});
  assign dx   = ax_e - bx_e;
  assign dy   = ay_e - by_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    g1.rest   <= params[REST_LSB +: REST_W];
    g1.kval   <= params[K_LSB +: K_W];
    g1.lim    <= params[LIM_LSB +: LIM_W];
    g1.ax     <= '0;
    g1.ay     <= '0;
    g1.dx_neg <= dx[DIFF_W-1];
    g1.dy_neg <= dy[DIFF_W-1];
    dx1       <= dx;
    dy1       <= dy;

    g2.rest   <= g1.rest;
    g2.kval   <= g1.kval;
    g2.lim    <= g1.lim;
    g2.dx_neg <= g1.dx_neg;
    g2.dy_neg <= g1.dy_neg;
    g2.ax     <= dx1[DIFF_W-1] ? ABS_W'(-dx1) : ABS_W'(dx1);
    g2.ay     <= dy1[DIFF_W-1] ? ABS_W'(-dy1) : ABS_W'(dy1);

    g3  <= g2;
    sx3 <= SQ_W'(g2.ax) * SQ_W'(g2.ax);
    sy3 <= SQ_W'(g2.ay) * SQ_W'(g2.ay);

    out_geom <= g3;
    out_sum  <= {1'b0, sx3} + {1'b0, sy3};
  end

endmodule

// ===== hdl/sfl_sqrt.sv =====
// Pipelined digit-by-digit square root, one result bit per stage.
// Depends on sfl_pkg.
module sfl_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [sfl_pkg::SUM_W-1:0]   in_sum,
  input  sfl_pkg::geom_t              in_geom,
  output logic                        out_valid,
  output logic [sfl_pkg::DIST_W-1:0]  out_dist,
  output sfl_pkg::geom_t              out_geom
);
  import sfl_pkg::*;

  localparam int NS    = SQRT_STAGES;
  localparam int RAD_W = 2 * NS;
  localparam int REM_W = DIST_W + 1;
  localparam int CUR_W = REM_W + 2;

  logic              vld  [1:NS];
  logic [REM_W-1:0]  rem  [1:NS];
  logic [DIST_W-1:0] root [1:NS];
  logic [RAD_W-1:0]  rad  [1:NS];
  geom_t             geo  [1:NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic              pv;
    logic [REM_W-1:0]  prem;
    logic [DIST_W-1:0] proot;
    logic [RAD_W-1:0]  prad;
    geom_t             pgeo;
    logic [CUR_W-1:0]  cur, trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = RAD_W'(in_sum);
      assign pgeo  = in_geom;
    end else begin : g_next
      assign pv    = vld[g];
      assign prem  = rem[g];
      assign proot = root[g];
      assign prad  = rad[g];
      assign pgeo  = geo[g];
    end

    assign cur   = {prem, prad[RAD_W-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[g+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
      root[g+1] <= {proot[DIST_W-2:0], ge};
      rad[g+1]  <= {prad[RAD_W-3:0], 2'b00};
      geo[g+1]  <= pgeo;
    end
  end

  assign out_valid = vld[NS];
  assign out_dist  = root[NS];
  assign out_geom  = geo[NS];

endmodule

// ===== hdl/sfl_scale.sv =====
// Stretch, saturated extension, force magnitude and clamp to the limit.
// Depends on sfl_pkg.
module sfl_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [sfl_pkg::DIST_W-1:0]  in_dist,
  input  sfl_pkg::geom_t              in_geom,
  output logic                        out_valid,
  output logic [sfl_pkg::ABS_W-1:0]   out_ax,
  output logic [sfl_pkg::ABS_W-1:0]   out_ay,
  output logic [sfl_pkg::DIST_W-1:0]  out_dist,
  output sfl_pkg::div_tag_t           out_tag
);
  import sfl_pkg::*;

  logic                    v1, v2, v3;
  logic [DIST_W-1:0]       d1, d2, d3;
  geom_t                   g1;
  logic signed [STR_W-1:0] st1;

  logic [ABS_W-1:0]   ax2, ay2, ax3, ay3;
  logic [K_W-1:0]     k2;
  logic [LIM_W-1:0]   lim2, lim3;
  logic [AS_W-1:0]    as2;
  logic [FIELD_W-1:0] ext2, ext3;
  logic               z2, nx2, ny2, z3, nx3, ny3;
  logic [MR_W-1:0]    mr3;

  logic               neg1;
  logic [AS_W-1:0]    abs1;
  logic [FIELD_W-1:0] ext1;
  logic [MAG_W-1:0]   cap;

  assign neg1 = st1[STR_W-1];
  assign abs1 = neg1 ? AS_W'(-st1) : AS_W'(st1);
  assign cap  = {lim3, {CAP_SHIFT{1'b0}}};

  always_comb begin
    if (!neg1 && (st1[STR_W-2:FIELD_W-1] != '0)) begin
      ext1 = SAT_POS;
    end else if (neg1 && (st1[STR_W-2:FIELD_W-1] != '1)) begin
      ext1 = SAT_NEG;
    end else begin
      ext1 = st1[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    d1  <= in_dist;
    g1  <= in_geom;
    st1 <= signed'({1'b0, in_dist})
           - signed'({2'b00, in_geom.rest, {REST_SHIFT{1'b0}}});

    d2   <= d1;
    ax2  <= g1.ax;
    ay2  <= g1.ay;
    k2   <= g1.kval;
    lim2 <= g1.lim;
    as2  <= abs1;
    ext2 <= ext1;
    z2   <= (d1 == '0) || (st1 == '0);
    nx2  <= (g1.ax != '0) && (g1.dx_neg == neg1);
    ny2  <= (g1.ay != '0) && (g1.dy_neg == neg1);

    d3   <= d2;
    ax3  <= ax2;
    ay3  <= ay2;
    lim3 <= lim2;
    ext3 <= ext2;
    z3   <= z2;
    nx3  <= nx2;
    ny3  <= ny2;
    mr3  <= MR_W'(k2) * MR_W'(as2);

    out_dist      <= d3;
    out_ax        <= ax3;
    out_ay        <= ay3;
    out_tag.mag   <= (mr3 > MR_W'(cap)) ? cap : MAG_W'(mr3);
    out_tag.ext   <= ext3;
    out_tag.neg_x <= nx3;
    out_tag.neg_y <= ny3;
    out_tag.zero  <= z3;
  end

endmodule

// ===== hdl/sfl_div.sv =====
// Two-lane pipelined restoring divider for the unit direction, one quotient bit per stage.
// Depends on sfl_pkg.
module sfl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [sfl_pkg::ABS_W-1:0]   in_ax,
  input  logic [sfl_pkg::ABS_W-1:0]   in_ay,
  input  logic [sfl_pkg::DIST_W-1:0]  in_dist,
  input  sfl_pkg::div_tag_t           in_tag,
  output logic                        out_valid,
  output logic [sfl_pkg::Q_W-1:0]     out_qx,
  output logic [sfl_pkg::Q_W-1:0]     out_qy,
  output sfl_pkg::div_tag_t           out_tag
);
  import sfl_pkg::*;

  localparam int NS    = DIV_STAGES;
  localparam int REM_W = DIST_W;
  localparam int CUR_W = REM_W + 1;

  logic              vld [1:NS];
  logic [REM_W-1:0]  rx  [1:NS];
  logic [REM_W-1:0]  ry  [1:NS];
  logic [Q_W-1:0]    qx  [1:NS];
  logic [Q_W-1:0]    qy  [1:NS];
  logic [DIST_W-1:0] dv  [1:NS];
  div_tag_t          tg  [1:NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic              pv;
    logic [REM_W-1:0]  prx, pry;
    logic [Q_W-1:0]    pqx, pqy;
    logic [DIST_W-1:0] pd;
    div_tag_t          ptg;
    logic              bx, by;
    logic [CUR_W-1:0]  cx, cy, dd;
    logic              gx, gy;

    if (g == 0) begin : g_first
      assign pv  = in_valid;
      assign prx = REM_W'(in_ax[ABS_W-1:1]);
      assign pry = REM_W'(in_ay[ABS_W-1:1]);
      assign pqx = '0;
      assign pqy = '0;
      assign pd  = in_dist;
      assign ptg = in_tag;
      assign bx  = in_ax[0];
      assign by  = in_ay[0];
    end else begin : g_next
      assign pv  = vld[g];
      assign prx = rx[g];
      assign pry = ry[g];
      assign pqx = qx[g];
      assign pqy = qy[g];
      assign pd  = dv[g];
      assign ptg = tg[g];
      assign bx  = 1'b0;
      assign by  = 1'b0;
    end

    assign cx = {prx, bx};
    assign cy = {pry, by};
    assign dd = {1'b0, pd};
    assign gx = (cx >= dd);
    assign gy = (cy >= dd);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rx[g+1] <= gx ? REM_W'(cx - dd) : REM_W'(cx);
      ry[g+1] <= gy ? REM_W'(cy - dd) : REM_W'(cy);
      qx[g+1] <= {pqx[Q_W-2:0], gx};
      qy[g+1] <= {pqy[Q_W-2:0], gy};
      dv[g+1] <= pd;
      tg[g+1] <= ptg;
    end
  end

  assign out_valid = vld[NS];
  assign out_qx    = qx[NS];
  assign out_qy    = qy[NS];
  assign out_tag   = tg[NS];

endmodule
